[src/gbjs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbjs_pkg
// Types, register indexes and constants shared by the gamepad scanner files.
// ----------------------------------------------------------------------------
package gbjs_pkg;

    localparam int NUM_BUTTONS = 12;
    localparam int FIELD_W     = 12;
    localparam int ADC_W       = 16;
    localparam int THR_W       = 15;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 15;

    // buttons beyond the field width or NUM_BUTTONS are never reported
    localparam logic [FIELD_W-1:0] BUTTON_SPAN = (NUM_BUTTONS >= FIELD_W) ?
        {FIELD_W{1'b1}} : FIELD_W'((64'd1 << NUM_BUTTONS) - 64'd1);

    // direction bits inside the button field
    localparam int DIR_LEFT  = 0;
    localparam int DIR_UP    = 1;
    localparam int DIR_RIGHT = 2;
    localparam int DIR_DOWN  = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AVAILABLE_MASK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HIGH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANALOG_MODE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_THR     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_THR       = 3'd4;

    localparam logic [THR_W-1:0] SWITCH_THR_RESET = 15'h3000;
    localparam logic [THR_W-1:0] KEEP_THR_RESET   = 15'h2000;

    localparam logic signed [ADC_W-1:0] AXIS_MIN = 16'sh8000;
    localparam logic signed [ADC_W-1:0] AXIS_MAX = 16'sh7fff;

    typedef struct packed {
        logic [FIELD_W-1:0] available_mask;
        logic               active_high;
        logic               analog_mode;
        logic [THR_W-1:0]   switch_threshold;
        logic [THR_W-1:0]   keep_threshold;
    } t_cfg;

    typedef struct packed {
        logic [FIELD_W-1:0] pin_levels;
        logic [ADC_W-1:0]   adc_x;
        logic [ADC_W-1:0]   adc_y;
    } t_sample;

    typedef struct packed {
        logic [FIELD_W-1:0]       pressed;
        logic signed [ADC_W-1:0]  pos_x;
        logic signed [ADC_W-1:0]  pos_y;
        logic                     changed;
        logic [FIELD_W-1:0]       led_levels;
    } t_result;

    // scanner state carried from one sample to the next
    typedef struct packed {
        logic [FIELD_W-1:0] held_buttons;
        logic [FIELD_W-1:0] led_drive;
    } t_state;

endpackage
`default_nettype wire

[src/gbjs_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbjs_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface gbjs_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[src/gbjs_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbjs_cfg_regs
// Configuration register file written through the plain write port.
// ----------------------------------------------------------------------------
module gbjs_cfg_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [gbjs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [gbjs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output gbjs_pkg::t_cfg                       o_cfg
);
    import gbjs_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.available_mask   <= '0;
            r_cfg.active_high      <= 1'b0;
            r_cfg.analog_mode      <= 1'b0;
            r_cfg.switch_threshold <= SWITCH_THR_RESET;
            r_cfg.keep_threshold   <= KEEP_THR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_AVAILABLE_MASK: r_cfg.available_mask   <= i_cfg_data[FIELD_W-1:0];
                REG_ACTIVE_HIGH:    r_cfg.active_high      <= i_cfg_data[0];
                REG_ANALOG_MODE:    r_cfg.analog_mode      <= i_cfg_data[0];
                REG_SWITCH_THR:     r_cfg.switch_threshold <= i_cfg_data[THR_W-1:0];
                REG_KEEP_THR:       r_cfg.keep_threshold   <= i_cfg_data[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

[src/gbjs_eval.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbjs_eval
// Single-pass evaluation of one sample: button decode, axes, hysteresis
// direction bits and the next scanner state.
// ----------------------------------------------------------------------------
module gbjs_eval (
    input  wire gbjs_pkg::t_cfg    i_cfg,
    input  wire gbjs_pkg::t_sample i_sample,
    input  wire gbjs_pkg::t_state  i_state,
    output gbjs_pkg::t_result      o_result,
    output gbjs_pkg::t_state       o_state
);
    import gbjs_pkg::*;

    logic [FIELD_W-1:0]      avail;
    logic [FIELD_W-1:0]      level;
    logic [FIELD_W-1:0]      btns_raw;
    logic [FIELD_W-1:0]      btns;
    logic [FIELD_W-1:0]      held;
    logic signed [ADC_W-1:0] ana_x;
    logic signed [ADC_W-1:0] ana_y;
    logic signed [ADC_W-1:0] pos_x;
    logic signed [ADC_W-1:0] pos_y;
    logic signed [ADC_W:0]   lim_l;
    logic signed [ADC_W:0]   lim_r;
    logic signed [ADC_W:0]   lim_u;
    logic signed [ADC_W:0]   lim_d;
    logic [3:0]              dir;
    logic                    changed;
    logic [FIELD_W-1:0]      led_next;

    always_comb begin
        held     = i_state.held_buttons;
        avail    = i_cfg.available_mask & BUTTON_SPAN;
        level    = i_cfg.active_high ? i_sample.pin_levels : ~i_sample.pin_levels;
        btns_raw = level & avail;

        // recentring by 0x8000 is a flip of the top bit
        ana_x = {~i_sample.adc_x[ADC_W-1], i_sample.adc_x[ADC_W-2:0]};
        ana_y = {~i_sample.adc_y[ADC_W-1], i_sample.adc_y[ADC_W-2:0]};

        // held direction compares against keep threshold
        lim_l = {2'b00, held[DIR_LEFT]  ? i_cfg.keep_threshold : i_cfg.switch_threshold};
        lim_r = {2'b00, held[DIR_RIGHT] ? i_cfg.keep_threshold : i_cfg.switch_threshold};
        lim_u = {2'b00, held[DIR_UP]    ? i_cfg.keep_threshold : i_cfg.switch_threshold};
        lim_d = {2'b00, held[DIR_DOWN]  ? i_cfg.keep_threshold : i_cfg.switch_threshold};

        dir = '0;
        dir[DIR_LEFT]  = (ADC_W+1)'(ana_x) < -lim_l;
        dir[DIR_RIGHT] = (ADC_W+1)'(ana_x) >  lim_r;
        dir[DIR_UP]    = (ADC_W+1)'(ana_y) < -lim_u;
        dir[DIR_DOWN]  = (ADC_W+1)'(ana_y) >  lim_d;

        if (i_cfg.analog_mode) begin
            pos_x = ana_x;
            pos_y = ana_y;
            btns  = btns_raw | {{(FIELD_W-4){1'b0}}, dir};
        end else begin
            // left wins over right, up wins over down
            if (btns_raw[DIR_LEFT]) begin
                pos_x = AXIS_MIN;
            end else if (btns_raw[DIR_RIGHT]) begin
                pos_x = AXIS_MAX;
            end else begin
                pos_x = '0;
            end
            if (btns_raw[DIR_UP]) begin
                pos_y = AXIS_MIN;
            end else if (btns_raw[DIR_DOWN]) begin
                pos_y = AXIS_MAX;
            end else begin
                pos_y = '0;
            end
            btns = btns_raw;
        end

        changed = (btns != held);
        // led low for pressed and high for released available buttons, unavailable ones keep their drive
        led_next = changed ? ((i_state.led_drive & ~avail) | (~btns & avail))
                           : i_state.led_drive;

        o_state.held_buttons = changed ? btns : held;
        o_state.led_drive    = led_next;

        o_result.pressed    = btns;
        o_result.pos_x      = pos_x;
        o_result.pos_y      = pos_y;
        o_result.changed    = changed;
        o_result.led_levels = led_next;
    end

endmodule
`default_nettype wire

[src/gamepad_button_joystick_scanner.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gamepad_button_joystick_scanner
// Button and joystick sample scanner with threshold hysteresis on directions.
// ----------------------------------------------------------------------------
// Each sample beat is taken into an input register, evaluated in one pass of
// short compare and mask logic, and placed in a result register; one result
// beat comes out for every sample beat once the output side is ready. A new
// sample can be accepted every cycle while the result register is free or
// draining: the pressed set and LED drive state are updated in the same cycle
// the sample moves to the result register, so the next sample sees them at
// once. The output register decouples the two sides, so one sample is still
// taken while a result waits. Configuration is written through i_cfg_we/
// i_cfg_idx/i_cfg_data; indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
module gamepad_button_joystick_scanner (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [gbjs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [gbjs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    gbjs_stream_if.sink                          i_in,
    gbjs_stream_if.source                        o_out
);
    import gbjs_pkg::*;

    t_cfg    cfg;
    t_sample r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    t_state  r_state;
    t_state  n_state;
    t_result n_out;
    logic    advance;

    gbjs_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    gbjs_eval u_eval (
        .i_cfg    (cfg),
        .i_sample (r_in),
        .i_state  (r_state),
        .o_result (n_out),
        .o_state  (n_state)
    );

    // sample moves on when the result register is free or draining
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid            <= 1'b0;
            r_out_valid           <= 1'b0;
            r_state.held_buttons  <= '0;
            r_state.led_drive     <= '1;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in <= i_in.payload;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule
`default_nettype wire
